FILE: rtl/core/siq_pkg.sv
package siq_pkg;

    // Request codes carried in tuser of the input stream.
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_NTH   = 3'd1;
    localparam logic [2:0] REQ_ELEM  = 3'd2;
    localparam logic [2:0] REQ_CAR   = 3'd3;
    localparam logic [2:0] REQ_CDR   = 3'd4;
    localparam logic [2:0] REQ_FIND  = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_KIND  = 3'd2;
    localparam logic [2:0] ST_NOOFF = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;

    // Object kinds.
    localparam logic [1:0] KIND_LIST     = 2'd1;
    localparam logic [1:0] KIND_PAIRLIST = 2'd2;

    // Configuration register indexes.
    localparam logic REG_OBJECT_COUNT = 1'b0;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 16;

    // One table entry as it is held in the object memory.
    typedef struct packed {
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [10:0] parent;
        logic        has_tag;
        logic        attr_flag;
        logic [1:0]  kind;
    } entry_t;

endpackage

FILE: rtl/core/serial_index_child_and_offset_query.sv
// Preorder object table with child lookup and offset search.
//
// Items arrive as beats on the slave stream: tuser carries the request code
// and tdata the load and query fields. A load beat writes one table entry;
// a query beat walks the children of an object, indexes a generic list,
// takes the car or cdr of a pairlist, or bisects the table for a start
// offset. Every input beat yields exactly one result beat on the master
// stream. The object count register sits on the APB port at address 0.
//
// The block handles one item at a time and is not ready while an item is
// in work. A load or an early error goes through the done state to the output
// register. A child walk scans the entries that follow the object, and
// every scanned entry costs one read of the single port object memory
// and one compare step. An offset search likewise costs one memory read
// and one compare step for each bisection probe.
//
// Reset clears the object count and the control state; table contents are
// undefined until loaded. When the receiver stalls, the finished result
// waits in the output register and the next item, once taken, waits
// after its work until that register is free.
module serial_index_child_and_offset_query #(
    parameter int MAX_OBJECTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, lowest bit up: entry_index[9:0], entry_start[41:10],
    // entry_end[73:42], entry_parent[84:74], entry_kind[86:85],
    // entry_attr_flag[87], entry_has_tag[88], query_id[98:89],
    // query_n[108:99], query_offset[140:109], zero fill [143:141]
    input  logic [siq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]                     s_axis_tuser,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, lowest bit up: result_id[9:0], not_found[10], status[13:11],
    // zero fill [15:14]
    output logic [siq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IW = $clog2(MAX_OBJECTS);
    localparam int LW = $clog2(MAX_OBJECTS + 1);
    localparam int XW = (LW > 11) ? LW : 11;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_OBJ        = 3'd1;
    localparam logic [2:0] S_WALK_ISSUE = 3'd2;
    localparam logic [2:0] S_WALK_CHECK = 3'd3;
    localparam logic [2:0] S_SRCH_ISSUE = 3'd4;
    localparam logic [2:0] S_SRCH_CHECK = 3'd5;
    localparam logic [2:0] S_DONE       = 3'd6;

    // Input field views.
    logic [9:0]  in_entry_index;
    logic [31:0] in_entry_start;
    logic [31:0] in_entry_end;
    logic [10:0] in_entry_parent;
    logic [1:0]  in_entry_kind;
    logic        in_entry_attr_flag;
    logic        in_entry_has_tag;
    logic [9:0]  in_query_id;
    logic [9:0]  in_query_n;
    logic [31:0] in_query_offset;

    assign in_entry_index     = s_axis_tdata[9:0];
    assign in_entry_start     = s_axis_tdata[41:10];
    assign in_entry_end       = s_axis_tdata[73:42];
    assign in_entry_parent    = s_axis_tdata[84:74];
    assign in_entry_kind      = s_axis_tdata[86:85];
    assign in_entry_attr_flag = s_axis_tdata[87];
    assign in_entry_has_tag   = s_axis_tdata[88];
    assign in_query_id        = s_axis_tdata[98:89];
    assign in_query_n         = s_axis_tdata[108:99];
    assign in_query_offset    = s_axis_tdata[140:109];

    // Configuration register.
    logic [10:0] object_count_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[2] == siq_pkg::REG_OBJECT_COUNT) && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == siq_pkg::REG_OBJECT_COUNT)
                    ? {21'd0, object_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_count_reg <= 11'd0;
        end
        else if (cfg_wr)
        begin
            object_count_reg <= pwdata[10:0];
        end
    end

    // Number of valid entries, limited to the table depth.
    logic [LW-1:0] len_w;
    assign len_w = (XW'(object_count_reg) > XW'(MAX_OBJECTS))
                   ? LW'(MAX_OBJECTS) : LW'(object_count_reg);

    // Control and working registers.
    logic [2:0]      state_reg, state_next;
    logic [2:0]      req_reg, req_next;
    logic [IW-1:0]   obj_reg, obj_next;
    logic [31:0]     lim_reg, lim_next;
    logic [31:0]     off_reg, off_next;
    logic [9:0]      nq_reg, nq_next;
    logic [9:0]      tgt_reg, tgt_next;
    logic [9:0]      cnt_reg, cnt_next;
    logic [LW-1:0]   k_reg, k_next;
    logic signed [LW:0] lo_reg, lo_next;
    logic signed [LW:0] hi_reg, hi_next;
    logic signed [LW:0] mid_reg, mid_next;
    logic [9:0]      res_id_reg, res_id_next;
    logic            res_nf_reg, res_nf_next;
    logic [2:0]      res_st_reg, res_st_next;
    logic            out_valid_reg, out_valid_next;
    logic [siq_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Object memory, one read port with registered data.
    siq_pkg::entry_t mem [MAX_OBJECTS];
    siq_pkg::entry_t rd_data_reg;
    siq_pkg::entry_t wr_entry;
    logic [IW-1:0]   rd_addr;
    logic            mem_wr;
    logic            in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign mem_wr  = in_fire && (s_axis_tuser == siq_pkg::REQ_LOAD) &&
                     ({1'b0, in_entry_index} < 11'(MAX_OBJECTS > 1024 ? 1024 : MAX_OBJECTS));

    always_comb
    begin
        wr_entry.start_off = in_entry_start;
        wr_entry.end_off   = in_entry_end;
        wr_entry.parent    = in_entry_parent;
        wr_entry.has_tag   = in_entry_has_tag;
        wr_entry.attr_flag = in_entry_attr_flag;
        wr_entry.kind      = in_entry_kind;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[IW'(in_entry_index)] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer helpers.
    logic [LW-1:0]      k_inc;
    logic signed [LW:0] mid_calc;
    logic [9:0]         extra;

    assign k_inc    = k_reg + LW'(1);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign extra    = 10'(rd_data_reg.attr_flag) + 10'(rd_data_reg.has_tag);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        obj_next       = obj_reg;
        lim_next       = lim_reg;
        off_next       = off_reg;
        nq_next        = nq_reg;
        tgt_next       = tgt_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_id_next    = res_id_reg;
        res_nf_next    = res_nf_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = obj_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = IW'(in_query_id);
                if (s_axis_tvalid)
                begin
                    req_next    = s_axis_tuser;
                    obj_next    = IW'(in_query_id);
                    off_next    = in_query_offset;
                    nq_next     = in_query_n;
                    res_id_next = 10'd0;
                    res_nf_next = 1'b0;
                    res_st_next = siq_pkg::ST_OK;
                    state_next  = S_DONE;
                    if (s_axis_tuser inside {siq_pkg::REQ_NTH, siq_pkg::REQ_ELEM,
                                             siq_pkg::REQ_CAR, siq_pkg::REQ_CDR,
                                             siq_pkg::REQ_FIND})
                    begin
                        if (s_axis_tuser == siq_pkg::REQ_ELEM && in_query_n == 10'd0)
                        begin
                            res_st_next = siq_pkg::ST_ZERO;
                        end
                        else if (XW'(in_query_id) >= XW'(len_w))
                        begin
                            res_st_next = siq_pkg::ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_OBJ;
                        end
                    end
                end
            end

            S_OBJ:
            begin
                // The object's own entry is now in the read register.
                lim_next = rd_data_reg.end_off;
                k_next   = LW'(obj_reg);
                cnt_next = 10'd0;
                lo_next  = $signed({1'b0, LW'(obj_reg)});
                hi_next  = $signed({1'b0, len_w}) - (LW+1)'(1);
                tgt_next = nq_reg;
                state_next = S_WALK_ISSUE;
                case (req_reg)
                    siq_pkg::REQ_NTH:
                    begin
                        tgt_next = nq_reg;
                    end
                    siq_pkg::REQ_ELEM:
                    begin
                        if (rd_data_reg.kind != siq_pkg::KIND_LIST)
                        begin
                            res_st_next = siq_pkg::ST_KIND;
                            state_next  = S_DONE;
                        end
                    end
                    siq_pkg::REQ_CAR, siq_pkg::REQ_CDR:
                    begin
                        tgt_next = ((req_reg == siq_pkg::REQ_CAR) ? 10'd1 : 10'd2) + extra;
                        if (rd_data_reg.kind != siq_pkg::KIND_PAIRLIST)
                        begin
                            res_st_next = siq_pkg::ST_KIND;
                            state_next  = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_SRCH_ISSUE;
                    end
                endcase
                // Child number zero names the object itself.
                if (state_next == S_WALK_ISSUE && tgt_next == 10'd0)
                begin
                    res_id_next = 10'(obj_reg);
                    state_next  = S_DONE;
                end
            end

            S_WALK_ISSUE:
            begin
                rd_addr = IW'(k_inc);
                if (k_inc >= len_w)
                begin
                    res_nf_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_WALK_CHECK;
                end
            end

            S_WALK_CHECK:
            begin
                state_next = S_WALK_ISSUE;
                if (XW'(rd_data_reg.parent) == XW'(obj_reg))
                begin
                    cnt_next = cnt_reg + 10'd1;
                    if (cnt_reg + 10'd1 == tgt_reg)
                    begin
                        res_id_next = 10'(k_reg);
                        state_next  = S_DONE;
                    end
                end
                else if (rd_data_reg.start_off >= lim_reg)
                begin
                    res_nf_next = 1'b1;
                    state_next  = S_DONE;
                end
            end

            S_SRCH_ISSUE:
            begin
                rd_addr = IW'(mid_calc);
                if (lo_reg > hi_reg)
                begin
                    res_st_next = siq_pkg::ST_NOOFF;
                    state_next  = S_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = S_SRCH_CHECK;
                end
            end

            S_SRCH_CHECK:
            begin
                state_next = S_SRCH_ISSUE;
                if (rd_data_reg.start_off == off_reg)
                begin
                    res_id_next = 10'(mid_reg);
                    state_next  = S_DONE;
                end
                else if (rd_data_reg.start_off < off_reg)
                begin
                    lo_next = mid_reg + (LW+1)'(1);
                end
                else
                begin
                    hi_next = mid_reg - (LW+1)'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, res_st_reg, res_nf_reg, res_id_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        obj_reg      <= obj_next;
        lim_reg      <= lim_next;
        off_reg      <= off_next;
        nq_reg       <= nq_next;
        tgt_reg      <= tgt_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        res_id_reg   <= res_id_next;
        res_nf_reg   <= res_nf_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
    end

endmodule
